### rtl/speq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted event priority queue package
// Shared widths, entry and control types, request and status codes.
// ----------------------------------------------------------------------------
package speq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CAP_W       = 7;
    localparam int CAP_RESET   = 64;
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int TIME_W      = 32;
    localparam int ID_W        = 16;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [ID_W-1:0]   id;
        logic              kind;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic remove;
    } op_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_QUERY  = 2'd2
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        CS_IDLE,
        CS_REPORT
    } ctrl_state_t;

endpackage

### rtl/sorted_event_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted event priority queue
// Each request first updates the row of cells, then loads the result register
// once the output is free. The queue is a row of QUEUE_DEPTH cells, head in
// cell 0; every cell compares its own time stamp with the new one in parallel,
// so an insert or remove moves the whole row by at most one slot at once.
// A new request is taken while an earlier result still waits on the output.
// Equal time stamps leave in insert order. The capacity register may be
// written at any time the queue is idle.
// ----------------------------------------------------------------------------
module sorted_event_priority_queue
    import speq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [REQ_W-1:0]       req_type,
    input  logic [TIME_W-1:0]      entry_time,
    input  logic [ID_W-1:0]        entry_id,
    input  logic                   entry_kind,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CAP_W-1:0]       cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [STATUS_W-1:0]    status,
    output logic                   head_valid,
    output logic [TIME_W-1:0]      head_time,
    output logic [ID_W-1:0]        head_id,
    output logic                   head_kind,
    output logic [COUNT_OUT_W-1:0] entry_count
);

    op_t                    op;
    logic [CNT_W-1:0]       count;
    entry_t                 new_entry;
    entry_t                 cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_keep;
    logic [QUEUE_DEPTH-1:0] cell_occ;

    assign new_entry.stamp = entry_time;
    assign new_entry.id    = entry_id;
    assign new_entry.kind  = entry_kind;

    speq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .head_entry  (cell_entry[0]),
        .op          (op),
        .count       (count),
        .status      (status),
        .head_valid  (head_valid),
        .head_time   (head_time),
        .head_id     (head_id),
        .head_kind   (head_kind),
        .entry_count (entry_count)
    );

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic   prev_keep;
        entry_t prev_entry;
        entry_t next_entry;

        assign cell_occ[i] = (count > CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign prev_keep  = 1'b1;
            assign prev_entry = new_entry;
        end
        else
        begin : g_mid
            assign prev_keep  = cell_keep[i-1];
            assign prev_entry = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign next_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign next_entry = cell_entry[i+1];
        end

        speq_cell u_cell (
            .clk        (clk),
            .op         (op),
            .new_entry  (new_entry),
            .occupied   (cell_occ[i]),
            .prev_keep  (prev_keep),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .keep       (cell_keep[i]),
            .entry      (cell_entry[i])
        );
    end

endmodule

### rtl/speq_cell.sv
// ----------------------------------------------------------------------------
// Sorted event priority queue cell
// One slot of the sorted row: holds, takes the new entry, or takes a neighbor.
// ----------------------------------------------------------------------------
module speq_cell
    import speq_pkg::*;
(
    input  logic   clk,
    input  op_t    op,
    input  entry_t new_entry,
    input  logic   occupied,
    input  logic   prev_keep,
    input  entry_t prev_entry,
    input  entry_t next_entry,
    output logic   keep,
    output entry_t entry
);

    entry_t entry_reg;
    entry_t entry_next;

    assign keep  = occupied && (entry_reg.stamp <= new_entry.stamp);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (op.insert)
        begin
            if (!keep)
            begin
                entry_next = prev_keep ? new_entry : prev_entry;
            end
        end
        else if (op.remove)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

### rtl/speq_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted event priority queue control
// Request decode, entry count, capacity register and result register.
// ----------------------------------------------------------------------------
module speq_ctrl
    import speq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [REQ_W-1:0]       req_type,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CAP_W-1:0]       cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  entry_t                 head_entry,
    output op_t                    op,
    output logic [CNT_W-1:0]       count,
    output logic [STATUS_W-1:0]    status,
    output logic                   head_valid,
    output logic [TIME_W-1:0]      head_time,
    output logic [ID_W-1:0]        head_id,
    output logic                   head_kind,
    output logic [COUNT_OUT_W-1:0] entry_count
);

    ctrl_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CAP_W-1:0]     cap_reg;
    status_t              status_reg, status_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 load;
    logic                 accept;
    logic                 full;
    status_t              res_status_reg;
    logic                 res_valid_reg;
    entry_t               res_entry_reg;
    logic [CNT_W-1:0]     res_count_reg;

    assign in_ready  = (state_reg == CS_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign full      = (CMP_W'(count_reg) >= CMP_W'(cap_reg))
                       || (count_reg == CNT_W'(QUEUE_DEPTH));
    assign load      = (state_reg == CS_REPORT) && (!out_valid_reg || out_ready);
    assign count     = count_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        op             = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            CS_IDLE:
            begin
                if (accept)
                begin
                    state_next  = CS_REPORT;
                    status_next = ST_DONE;
                    case (req_type)
                        REQ_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                op.insert  = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                op.remove  = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            status_next = ST_DONE;
                        end
                    endcase
                end
            end
            CS_REPORT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_W'(CAP_RESET);
            status_reg    <= ST_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_status_reg <= status_reg;
            res_valid_reg  <= (count_reg != '0);
            res_entry_reg  <= head_entry;
            res_count_reg  <= count_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = res_status_reg;
    assign head_valid  = res_valid_reg;
    assign head_time   = res_valid_reg ? res_entry_reg.stamp : '0;
    assign head_id     = res_valid_reg ? res_entry_reg.id : '0;
    assign head_kind   = res_valid_reg ? res_entry_reg.kind : 1'b0;
    assign entry_count = COUNT_OUT_W'(res_count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond depth");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        op.insert |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not advance count");

    a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        op.remove |-> count_reg != '0)
        else $error("remove on empty queue");

    a_report_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_REPORT && !out_valid_reg) |=> out_valid_reg && state_reg == CS_IDLE)
        else $error("result not loaded");

endmodule
